// File: src/sm3_pkg.sv
// sm3 hash core package: payload structs, sequencer states, constants
// no dependencies
`timescale 1ns / 1ps
package sm3_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } sm3_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } sm3_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } sm3_state_t;

  localparam logic [31:0] T_LOW    = 32'h79cc4519;
  localparam logic [31:0] T_HIGH   = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int          BLOCK_WORDS = 16;
  localparam int          ROUNDS      = 64;

  localparam logic [31:0] IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] k);
    logic [63:0] d;
    d = {v, v} << k;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// File: src/sm3_hash_core.sv
// sm3 hash core top level: word packing, padding, one-round-per-cycle compression
// depends on sm3_pkg
`timescale 1ns / 1ps
// usage
// - input channel in_valid/in_stall/in_data carries one message word per transaction,
//   big-endian; last_word marks the final word, byte_count gives its valid bytes
// - output channel out_valid/out_stall/out_data returns eight digest words after
//   the final word, index 0 first, digest_last on the eighth
// - a word that completes no block is taken without a stall; the word that fills a
//   block starts the compression: a load step, 64 rounds and a fold step, and the
//   input stalls until the fold step is done
// - after the final word the padding words are pushed one per cycle, held while one or
//   two compressions run, then the eight digest words leave one per transaction
// - the round logic is one shared unit (one round per cycle) under the sequencer;
//   the schedule window is a 16 entry circular register file updated in place
// - in_stall is high whenever the sequencer is not idle
// - out_stall holds the current digest word until taken; no input is taken until
//   all eight are gone
// - synchronous active-low reset returns the chaining value to the initial vector
//   and clears the length counter and block position
module sm3_hash_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sm3_pkg::sm3_in_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sm3_pkg::sm3_out_t out_data
);
  import sm3_pkg::*;

  sm3_state_t state_r, state_nxt;
  logic [31:0] cv_r [8];
  logic [31:0] wr_r [8];
  logic [31:0] buf_r [16];
  logic [31:0] win_r [16];
  logic [63:0] len_r;
  logic [3:0]  pos_r;
  logic [5:0]  rnd_r;
  logic [1:0]  pad_r;      // 0: none, 1: zero fill, 2: length high, 3: length low
  logic        fin_r;      // final word taken; padding or digest output pending
  logic        extra_r;    // pending 0x80 word after a full last word
  logic [31:0] pend_r;
  logic [2:0]  oidx_r;

  // push path
  logic        push;
  logic [31:0] push_word;
  logic        acc;
  logic [2:0]  bc;
  logic [31:0] keep, tail;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    bc = (in_data.byte_count > 3'd4 || !in_data.last_word) ? 3'd4 : in_data.byte_count;
    keep = (bc == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {bc, 3'b000}));
    tail = (in_data.message_word & keep) |
           ({24'h0, PAD_BYTE} << (5'd24 - {bc[1:0], 3'b000}));
  end

  // one round unit
  logic [5:0]  j;
  logic [3:0]  n;
  logic [31:0] wnew, wj, wj4, tconst, a12, ss1, ss2, ff, gg, tt1, tt2;
  always_comb begin
    j = rnd_r;
    n = j[3:0] + 4'd4;
    wnew = p1(win_r[n] ^ win_r[n - 4'd9] ^ rotl(win_r[n - 4'd3], 5'd15))
           ^ rotl(win_r[n - 4'd13], 5'd7) ^ win_r[n - 4'd6];
    wj  = win_r[j[3:0]];
    wj4 = (j >= 6'd12) ? wnew : win_r[n];
    tconst = (j < 6'd16) ? T_LOW : T_HIGH;
    a12 = rotl(wr_r[0], 5'd12);
    ss1 = rotl(a12 + wr_r[4] + rotl(tconst, j[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j < 6'd16) begin
      ff = wr_r[0] ^ wr_r[1] ^ wr_r[2];
      gg = wr_r[4] ^ wr_r[5] ^ wr_r[6];
    end else begin
      ff = (wr_r[0] & wr_r[1]) | (wr_r[0] & wr_r[2]) | (wr_r[1] & wr_r[2]);
      gg = (wr_r[4] & wr_r[5]) | (~wr_r[4] & wr_r[6]);
    end
    tt1 = ff + wr_r[3] + ss2 + (wj ^ wj4);
    tt2 = gg + wr_r[7] + ss1 + wj;
  end

  // pushed word: the input word in ST_IDLE, or the next padding word in ST_PAD
  always_comb begin
    push = 1'b0;
    push_word = 32'h0;
    if (state_r == ST_IDLE && acc) begin
      push = 1'b1;
      push_word = (in_data.last_word && bc != 3'd4) ? tail : in_data.message_word;
    end else if (state_r == ST_PAD) begin
      push = 1'b1;
      if (extra_r) push_word = pend_r;
      else if (pad_r == 2'd2 || (pad_r == 2'd1 && pos_r == 4'd14)) push_word = len_r[63:32];
      else if (pad_r == 2'd3) push_word = len_r[31:0];
      else push_word = 32'h0;
    end
  end

  logic blk_full;
  assign blk_full = push && (pos_r == 4'd15);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (acc) begin
        if (blk_full) state_nxt = ST_LOAD;
        else if (in_data.last_word) state_nxt = ST_PAD;
      end
      ST_PAD:   if (blk_full) state_nxt = ST_LOAD;
                else if (pad_r == 2'd3) state_nxt = ST_EMIT;
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'(ROUNDS - 1)) state_nxt = ST_FOLD;
      ST_FOLD:  state_nxt = fin_r ? (pad_r == 2'd0 ? ST_EMIT : ST_PAD) : ST_IDLE;
      ST_EMIT:  if (!out_stall && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state_r == ST_EMIT);
    out_data.digest_word = cv_r[oidx_r];
    out_data.word_index  = oidx_r;
    out_data.digest_last = (oidx_r == 3'd7);
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push) buf_r[pos_r] <= push_word;
    if (state_r == ST_LOAD) begin
      for (int i = 0; i < BLOCK_WORDS; i++) win_r[i] <= buf_r[i];
      for (int i = 0; i < 8; i++) wr_r[i] <= cv_r[i];
    end else if (state_r == ST_ROUND) begin
      if (j >= 6'd12) win_r[n] <= wnew;
      wr_r[3] <= wr_r[2];
      wr_r[2] <= rotl(wr_r[1], 5'd9);
      wr_r[1] <= wr_r[0];
      wr_r[0] <= tt1;
      wr_r[7] <= wr_r[6];
      wr_r[6] <= rotl(wr_r[5], 5'd19);
      wr_r[5] <= wr_r[4];
      wr_r[4] <= p0(tt2);
    end
    if (state_r == ST_IDLE && acc) pend_r <= {PAD_BYTE, 24'h0};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
      len_r <= '0; pos_r <= '0; rnd_r <= '0; pad_r <= '0;
      fin_r <= 1'b0; extra_r <= 1'b0; oidx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (push) pos_r <= pos_r + 4'd1;
      if (state_r == ST_IDLE && acc) begin
        len_r <= len_r + 64'({bc, 3'b000});
        if (in_data.last_word) begin
          fin_r <= 1'b1;
          extra_r <= (bc == 3'd4);
          pad_r <= 2'd1;
        end
      end
      if (state_r == ST_PAD) begin
        if (extra_r) extra_r <= 1'b0;
        else if (pad_r == 2'd1) begin
          if (pos_r == 4'd14) pad_r <= 2'd3;
          else if (pos_r == 4'd13) pad_r <= 2'd2;
        end else if (pad_r == 2'd2) pad_r <= 2'd3;
        else if (pad_r == 2'd3) pad_r <= 2'd0;
      end
      // first padding push after the tail word: fill if position not 14
      if (state_r == ST_ROUND) rnd_r <= rnd_r + 6'd1;
      if (state_r == ST_FOLD) begin
        for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] ^ wr_r[i];
      end
      if (state_r == ST_EMIT && !out_stall) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
          len_r <= '0; pos_r <= '0; fin_r <= 1'b0; pad_r <= '0;
        end
      end
    end
  end

  // padding rule: fill zeros until the word position reaches 14, then the length
  // the zero-fill step moves to length once the push lands on slot 13, and starts
  // the length at once when it begins on slot 14

  a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_valid || in_stall) else $error("output overlaps input");
  a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_ROUND && rnd_r == 6'd0))
    else $error("round counter not cleared");

endmodule

// File: bench/sm3_hash_core_tb.sv
// testbench for sm3_hash_core: random and directed messages checked against an
// in-bench sm3 digest predictor; depends on sm3_pkg and sm3_hash_core
`timescale 1ns / 1ps
module sm3_hash_core_tb;
  import sm3_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sm3_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sm3_out_t out_data;

  sm3_hash_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  logic [31:0] hv [8];
  logic [31:0] blk [16];
  logic [63:0] msg_bits;
  int unsigned blk_pos;

  sm3_out_t digest_q [$];
  int mismatches;
  int idle_cycles = 0;
  int burst_left;
  bit stall_mode;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rol(input logic [31:0] v, input int k);
    int s;
    s = k % 32;
    if (s == 0) begin
      return v;
    end
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] perm_a(input logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] perm_b(input logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  task automatic fresh_message();
    for (int i = 0; i < 8; i++) begin
      hv[i] = IV[i];
    end
    msg_bits = '0;
    blk_pos = 0;
  endtask

  task automatic compress();
    logic [31:0] w [68];
    logic [31:0] r [8];
    logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) begin
      w[j] = blk[j];
    end
    for (int j = 16; j < 68; j++) begin
      w[j] = perm_b(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    end
    for (int i = 0; i < 8; i++) begin
      r[i] = hv[i];
    end
    for (int j = 0; j < 64; j++) begin
      t = (j < 16) ? T_LOW : T_HIGH;
      a12 = rol(r[0], 12);
      ss1 = rol(a12 + r[4] + rol(t, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + r[7] + ss1 + w[j];
      r[3] = r[2];
      r[2] = rol(r[1], 9);
      r[1] = r[0];
      r[0] = tt1;
      r[7] = r[6];
      r[6] = rol(r[5], 19);
      r[5] = r[4];
      r[4] = perm_a(tt2);
    end
    for (int i = 0; i < 8; i++) begin
      hv[i] ^= r[i];
    end
  endtask

  task automatic append_word(input logic [31:0] w);
    blk[blk_pos] = w;
    blk_pos = (blk_pos + 1) % 16;
    if (blk_pos == 0) begin
      compress();
    end
  endtask

  // updates the predictor with one accepted transaction
  task automatic predict_word(input sm3_in_t item);
    int nb;
    logic [31:0] keep, word;
    nb = item.byte_count;
    if (nb > 4 || !item.last_word) begin
      nb = 4;
    end
    msg_bits += 64'(8 * nb);
    if (!item.last_word) begin
      append_word(item.message_word);
      return;
    end
    if (nb == 4) begin
      append_word(item.message_word);
      word = {PAD_BYTE, 24'h0};
    end else begin
      keep = (nb == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nb));
      word = (item.message_word & keep) | (32'(PAD_BYTE) << (24 - 8 * nb));
    end
    append_word(word);
    if (blk_pos > 14) begin
      append_word(32'h0);
    end
    while (blk_pos < 14) begin
      append_word(32'h0);
    end
    append_word(msg_bits[63:32]);
    append_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      digest_q.push_back(sm3_out_t'{digest_word: hv[i], word_index: 3'(i),
                                    digest_last: (i == 7)});
    end
    fresh_message();
  endtask

  // sends one transaction, with bursts and random gaps
  task automatic send_word(input logic [31:0] w, input int bc, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data <= sm3_in_t'{message_word: w, byte_count: 3'(bc), last_word: last};
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_word(sm3_in_t'{message_word: w, byte_count: 3'(bc), last_word: last});
    burst_left--;
  endtask

  task automatic send_message(input int n_words, input int last_bc);
    for (int i = 0; i < n_words; i++) begin
      send_word($urandom(), (i == n_words - 1) ? last_bc : $urandom_range(0, 7),
                i == n_words - 1);
    end
  endtask

  task automatic test_empty_and_short();
    send_word($urandom(), 0, 1'b1);
    send_word(32'h61626300, 3, 1'b1);
    send_word(32'hffffffff, 4, 1'b1);
    send_word(32'h00000000, 1, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_word(32'hffffffff, 0, 1'b0);
    send_word(32'h00000000, 7, 1'b0);
    send_word(32'hdeadbeef, 5, 1'b1);
    send_word(32'h12345678, 2, 1'b1);
    send_word(32'hffffffff, 6, 1'b1);
  endtask

  task automatic test_block_edges();
    send_message(13, 4);
    send_message(14, 3);
    send_message(15, 0);
    send_message(16, 4);
  endtask

  task automatic test_random_messages();
    int sent;
    sent = 0;
    while (sent < 250) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 18);
      send_message(n, $urandom_range(0, 7));
      sent += n;
    end
  endtask

  // receiver stall pattern: alternates between free-running and random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) begin
        stall_mode <= ~stall_mode;
      end
      out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
    end
  end

  // result checker: compare each digest transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected digest word %h idx %0d", out_data.digest_word,
                   out_data.word_index);
        end
      end else begin
        sm3_out_t exp_w;
        exp_w = digest_q.pop_front();
        if (exp_w !== out_data) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                     exp_w.digest_word, exp_w.word_index, exp_w.digest_last,
                     out_data.digest_word, out_data.word_index, out_data.digest_last);
          end
        end
      end
    end
  end

  // watchdog on cycles with no accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL sm3_hash_core");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    burst_left = 0;
    fresh_message();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_short();
    test_field_extremes();
    test_block_edges();
    test_random_messages();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS sm3_hash_core");
    end else begin
      $display("FAIL sm3_hash_core");
    end
    $finish;
  end

endmodule

// File: sm3_hash_core.f
src/sm3_pkg.sv
src/sm3_hash_core.sv
bench/sm3_hash_core_tb.sv
